>>> src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only outside reset.
`define ASSERT_CLK(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Checked at every edge, reset included.
`define ASSERT_ALWAYS(name, prop, msg) \
	name: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> src/jcre_pkg.sv
// ----------------------------------------------------------------------------
// JPEG coefficient run expander package
// Shared types, codes and constants of the run expander.
// ----------------------------------------------------------------------------
package jcre_pkg;

	localparam int DEF_MAX_BLOCKS     = 10;
	localparam int DEF_MAX_COMPONENTS = 3;
	localparam int DEF_QUEUE_DEPTH    = 2;
	localparam int COEFFS_PER_BLOCK   = 64;
	localparam int MAX_SIZE_BITS      = 11;
	localparam int ZRL_SKIP           = 16;
	localparam int SF_BYTES           = 3;

	localparam int CFG_INDEX_W = 1;
	localparam int CFG_DATA_W  = 24;
	localparam int TOTAL_W     = 10;

	localparam logic [1:0] CMD_SYMBOL  = 2'd0;
	localparam logic [1:0] CMD_RESTART = 2'd1;
	localparam logic [1:0] CMD_SCAN    = 2'd2;

	localparam logic [7:0] EOB_SYMBOL = 8'h00;
	localparam logic [7:0] ZRL_SYMBOL = 8'hF0;

	localparam logic [CFG_INDEX_W-1:0] REG_COMPONENT_COUNT = 1'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_SAMPLING        = 1'd1;

	localparam logic [1:0]            COUNT_RESET    = 2'd1;
	localparam logic [CFG_DATA_W-1:0] SAMPLING_RESET = 24'h111111;

	typedef struct packed {
		logic [1:0]  command;
		logic [7:0]  symbol;
		logic [10:0] extra_bits;
	} in_item_t;

	typedef struct packed {
		logic [1:0]         component;
		logic [3:0]         block_slot;
		logic [5:0]         position;
		logic signed [15:0] coefficient;
		logic               coefficient_valid;
		logic               block_done;
		logic               mcu_done;
		logic               run_error;
	} out_item_t;

	typedef enum logic [1:0] {
		KIND_SYMBOL = 2'd0,
		KIND_CLEAR  = 2'd1,
		KIND_NONE   = 2'd2
	} kind_t;

	// Classified item as it waits in the queue.
	typedef struct packed {
		kind_t              kind;
		logic               dc_bad;
		logic               eob;
		logic               zrl;
		logic               ac_bad;
		logic [3:0]         run;
		logic signed [11:0] dc_mag;
		logic signed [11:0] ac_mag;
	} fe_item_t;

	// JPEG sign extension of the low size bits; zero for sizes outside 1..11.
	function automatic logic signed [11:0] magnitude(input logic [10:0] bits,
			input logic [3:0] size);
		logic [10:0] mask;
		logic [10:0] v;
		mask = 11'((12'd1 << size) - 12'd1);
		v = bits & mask;
		if (size == 4'd0 || size > 4'(MAX_SIZE_BITS)) begin
			return 12'sd0;
		end
		if (v[size - 4'd1]) begin
			return signed'({1'b0, v});
		end
		return signed'({1'b0, v} - {1'b0, mask});
	endfunction

endpackage

>>> src/jcre_front.sv
// ----------------------------------------------------------------------------
// Run expander front end
// Accepts input items and classifies commands and symbols for the back end.
// ----------------------------------------------------------------------------
module jcre_front (
	input  logic              in_valid,
	output logic              in_stall,
	input  jcre_pkg::in_item_t in_data,
	input  logic              queue_full,
	output logic              push,
	output jcre_pkg::fe_item_t push_data
);
	import jcre_pkg::*;

	assign in_stall = queue_full;
	assign push     = in_valid && !queue_full;

	always_comb begin
		push_data = '0;
		unique case (in_data.command)
			CMD_SYMBOL:            push_data.kind = KIND_SYMBOL;
			CMD_RESTART, CMD_SCAN: push_data.kind = KIND_CLEAR;
			default:               push_data.kind = KIND_NONE;
		endcase
		// Both readings of the symbol are prepared; the back end picks by position.
		push_data.dc_bad = in_data.symbol > 8'(MAX_SIZE_BITS);
		push_data.dc_mag = (in_data.symbol[7:4] == 4'd0)
			? magnitude(in_data.extra_bits, in_data.symbol[3:0]) : 12'sd0;
		push_data.eob    = in_data.symbol == EOB_SYMBOL;
		push_data.zrl    = in_data.symbol == ZRL_SYMBOL;
		push_data.ac_bad = in_data.symbol[3:0] > 4'(MAX_SIZE_BITS);
		push_data.run    = in_data.symbol[7:4];
		push_data.ac_mag = magnitude(in_data.extra_bits, in_data.symbol[3:0]);
	end

endmodule

>>> src/jcre_queue.sv
// ----------------------------------------------------------------------------
// Run expander item queue
// Small register queue between front end and back end.
// ----------------------------------------------------------------------------
module jcre_queue #(
	parameter int DEPTH = jcre_pkg::DEF_QUEUE_DEPTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  jcre_pkg::fe_item_t push_data,
	input  logic               pop,
	output jcre_pkg::fe_item_t head,
	output logic               not_empty,
	output logic               full
);
	import jcre_pkg::*;

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	fe_item_t           entry_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;

	assign not_empty = count_q != '0;
	assign full      = count_q == CNT_W'(DEPTH);
	assign head      = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	`include "assert_macros.svh"

	`ASSERT_CLK(a_count_bound, count_q <= CNT_W'(DEPTH), "queue count above depth")
	`ASSERT_CLK(a_pop_only, (pop && !push) |=> count_q == $past(count_q) - CNT_W'(1), "pop lost")
	`ASSERT_CLK(a_ptr_gap, (count_q == '0) |-> (wr_ptr_q == rd_ptr_q), "pointers out of step")

endmodule

>>> src/jcre_back.sv
// ----------------------------------------------------------------------------
// Run expander back end
// Holds layout, predictors and position; turns classified items into results.
// ----------------------------------------------------------------------------
module jcre_back #(
	parameter int MAX_BLOCKS     = jcre_pkg::DEF_MAX_BLOCKS,
	parameter int MAX_COMPONENTS = jcre_pkg::DEF_MAX_COMPONENTS
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_write,
	input  logic [jcre_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [jcre_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  jcre_pkg::fe_item_t                  head,
	input  logic                                not_empty,
	output logic                                pop,
	output logic                                out_valid,
	input  logic                                out_stall,
	output jcre_pkg::out_item_t                 out_data
);
	import jcre_pkg::*;

	localparam int SF_EXT_W = 8 * ((MAX_COMPONENTS > SF_BYTES) ? MAX_COMPONENTS : SF_BYTES);

	logic [1:0]            count_q;
	logic [CFG_DATA_W-1:0] sampling_q;

	// Layout derived from the registers, updated in the cycle after they change.
	logic [TOTAL_W-1:0] bound_q [MAX_COMPONENTS];
	logic [TOTAL_W-1:0] total_q;
	logic               layout_bad_q;
	logic [TOTAL_W-1:0] bound_d [MAX_COMPONENTS];
	logic [TOTAL_W-1:0] total_d;

	logic signed [15:0] pred_q [MAX_COMPONENTS];
	logic [5:0]         cidx_q;
	logic [3:0]         cur_q;
	logic               out_valid_q;
	out_item_t          out_q;

	logic               pred_we;
	logic signed [15:0] pred_new;
	logic signed [15:0] pred_sel;
	logic [5:0]         cidx_d;
	logic [3:0]         cur_d;
	logic               clear;
	logic [1:0]         comp;
	logic [3:0]         cur_eff;
	logic [6:0]         zrl_next;
	logic [6:0]         target;
	logic [4:0]         next_block;
	logic               found;
	out_item_t          res;

	assign pop       = not_empty && (!out_valid_q || !out_stall);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_comb begin
		logic [2:0]         ncomp;
		logic [SF_EXT_W-1:0] sf_ext;
		logic [7:0]          sf_byte;
		logic [7:0]          blocks;
		logic [TOTAL_W-1:0]  acc;
		ncomp = {1'b0, count_q};
		if (ncomp == 3'd0) begin
			ncomp = 3'd1;
		end
		if (ncomp > 3'(MAX_COMPONENTS)) begin
			ncomp = 3'(MAX_COMPONENTS);
		end
		sf_ext = SF_EXT_W'(sampling_q);
		acc = '0;
		for (int c = 0; c < MAX_COMPONENTS; c++) begin
			sf_byte = sf_ext[8*c +: 8];
			blocks = (3'(c) < ncomp)
				? {4'd0, sf_byte[7:4]} * {4'd0, sf_byte[3:0]} : 8'd0;
			acc = acc + TOTAL_W'(blocks);
			bound_d[c] = acc;
		end
		total_d = acc;
	end

	always_ff @(posedge clk) begin
		bound_q      <= bound_d;
		total_q      <= total_d;
		layout_bad_q <= (total_d == '0) || (total_d > TOTAL_W'(MAX_BLOCKS));
		out_q        <= pop ? res : out_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= COUNT_RESET;
			sampling_q <= SAMPLING_RESET;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_COMPONENT_COUNT: count_q    <= cfg_data[1:0];
				REG_SAMPLING:        sampling_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		res      = '0;
		pred_we  = 1'b0;
		pred_new = '0;
		pred_sel = '0;
		cidx_d   = cidx_q;
		cur_d    = cur_q;
		clear    = 1'b0;
		comp     = '0;
		found    = 1'b0;
		zrl_next = {1'b0, cidx_q} + 7'(ZRL_SKIP);
		target   = {1'b0, cidx_q} + {3'd0, head.run};
		cur_eff  = (TOTAL_W'(cur_q) >= total_q) ? 4'd0 : cur_q;
		for (int c = 0; c < MAX_COMPONENTS; c++) begin
			if (!found && TOTAL_W'(cur_eff) < bound_q[c]) begin
				comp  = 2'(c);
				found = 1'b1;
			end
		end
		for (int c = 0; c < MAX_COMPONENTS; c++) begin
			if (comp == 2'(c)) begin
				pred_sel = pred_q[c];
			end
		end
		next_block = {1'b0, cur_eff} + 5'd1;

		unique case (head.kind)
			KIND_CLEAR: clear = 1'b1;
			KIND_SYMBOL: begin
				if (layout_bad_q) begin
					res.run_error = 1'b1;
				end else begin
					cur_d = cur_eff;
					res.component  = comp;
					res.block_slot = cur_eff;
					if (cidx_q == '0) begin
						if (head.dc_bad) begin
							res.run_error  = 1'b1;
							res.block_done = 1'b1;
						end else begin
							pred_new = pred_sel + 16'(head.dc_mag);
							pred_we  = 1'b1;
							res.coefficient       = pred_new;
							res.coefficient_valid = 1'b1;
							cidx_d = 6'd1;
						end
					end else if (head.eob) begin
						res.block_done = 1'b1;
					end else if (head.zrl) begin
						if (zrl_next >= 7'(COEFFS_PER_BLOCK)) begin
							res.run_error  = zrl_next > 7'(COEFFS_PER_BLOCK);
							res.block_done = 1'b1;
						end else begin
							cidx_d = zrl_next[5:0];
						end
					end else if (head.ac_bad || target >= 7'(COEFFS_PER_BLOCK)) begin
						res.run_error  = 1'b1;
						res.block_done = 1'b1;
					end else begin
						res.coefficient       = 16'(head.ac_mag);
						res.coefficient_valid = 1'b1;
						res.position          = target[5:0];
						cidx_d = target[5:0] + 6'd1;
						// Writing the last position closes the block by itself.
						res.block_done = target[5:0] == 6'(COEFFS_PER_BLOCK - 1);
					end
					if (res.block_done) begin
						cidx_d = '0;
						if (TOTAL_W'(next_block) >= total_q) begin
							cur_d        = '0;
							res.mcu_done = 1'b1;
						end else begin
							cur_d = next_block[3:0];
						end
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < MAX_COMPONENTS; c++) begin
				pred_q[c] <= '0;
			end
			cidx_q      <= '0;
			cur_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				out_valid_q <= 1'b1;
				if (clear) begin
					for (int c = 0; c < MAX_COMPONENTS; c++) begin
						pred_q[c] <= '0;
					end
					cidx_q <= '0;
					cur_q  <= '0;
				end else begin
					for (int c = 0; c < MAX_COMPONENTS; c++) begin
						if (pred_we && comp == 2'(c)) begin
							pred_q[c] <= pred_new;
						end
					end
					cidx_q <= cidx_d;
					cur_q  <= cur_d;
				end
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	`include "assert_macros.svh"

	`ASSERT_CLK(a_mcu_in_block, (out_valid_q && out_q.mcu_done) |-> out_q.block_done,
		"MCU end without block end")
	`ASSERT_CLK(a_no_write_on_error,
		(out_valid_q && out_q.coefficient_valid) |-> !out_q.run_error,
		"coefficient written with an error")
	`ASSERT_CLK(a_clear_state, (pop && head.kind == KIND_CLEAR) |=>
		(cidx_q == '0 && cur_q == '0), "restart did not clear position")
	`ASSERT_CLK(a_block_end_pos, (pop && res.block_done) |=> cidx_q == '0,
		"position not reset at block end")

endmodule

>>> src/jpeg_coefficient_run_expander.sv
// ----------------------------------------------------------------------------
// JPEG coefficient run expander
// Expands decoded baseline JPEG symbols into coefficient positions and values.
// ----------------------------------------------------------------------------
// An accepted item is held in the queue; its result is registered in the
// back end, then offered. Throughput: one item per cycle while not stalled.
// A two-entry queue lets the input side keep moving while a result is stalled.
// Reset clears predictors, position and block counter, and returns the
// registers to one component with all sampling factors 1.
module jpeg_coefficient_run_expander #(
	parameter int MAX_BLOCKS     = jcre_pkg::DEF_MAX_BLOCKS,
	parameter int MAX_COMPONENTS = jcre_pkg::DEF_MAX_COMPONENTS,
	parameter int QUEUE_DEPTH    = jcre_pkg::DEF_QUEUE_DEPTH
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_write,
	input  logic [jcre_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [jcre_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  jcre_pkg::in_item_t               in_data,
	output logic                             out_valid,
	input  logic                             out_stall,
	output jcre_pkg::out_item_t              out_data
);
	import jcre_pkg::*;

	logic     push;
	logic     pop;
	logic     queue_full;
	logic     not_empty;
	fe_item_t push_data;
	fe_item_t head;

	jcre_front u_front (
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_data    (in_data),
		.queue_full (queue_full),
		.push       (push),
		.push_data  (push_data)
	);

	jcre_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.head      (head),
		.not_empty (not_empty),
		.full      (queue_full)
	);

	jcre_back #(
		.MAX_BLOCKS     (MAX_BLOCKS),
		.MAX_COMPONENTS (MAX_COMPONENTS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.head      (head),
		.not_empty (not_empty),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule
